>>> rtl/hrhp_pkg.sv
// Shared types, codes and constant string tables for the HTTP request header parser.
// No dependencies; imported by hrhp_parse and http_request_header_parser_core.
package hrhp_pkg;

  localparam int unsigned OffW    = 12;
  localparam int unsigned STdataW = 8;
  localparam int unsigned MTdataW = 80;

  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_REQUEST,
    ST_NOT_ALLOWED,
    ST_TOO_LARGE
  } status_e;

  typedef enum logic {
    KIND_TUPLE,
    KIND_VERDICT
  } kind_e;

  typedef enum logic [1:0] {
    METH_GET,
    METH_HEAD,
    METH_POST
  } method_e;

  typedef enum logic [1:0] {
    VER_0_9,
    VER_1_0,
    VER_1_1
  } version_e;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    method_e           method;
    version_e          version;
    logic [OffW-1:0]   url_start;
    logic [OffW-1:0]   url_end;
    logic [OffW-1:0]   name_start;
    logic [OffW-1:0]   name_end;
    logic [OffW-1:0]   value_start;
    logic [OffW-1:0]   value_end;
    logic              last;
  } result_t;

  function automatic logic [3:0] meth_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd3;
      2'd1:    n = 4'd4;
      2'd2:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] meth_chr(input logic [1:0] k, input logic [3:0] idx);
    logic [31:0] w;
    case (k)
      2'd0:    w = {"GET", 8'h00};
      2'd1:    w = "HEAD";
      2'd2:    w = "POST";
      default: w = '0;
    endcase
    return w[(5'd24 - {idx[1:0], 3'b000}) +: 8];
  endfunction

  localparam logic [3:0] VerLen = 4'd8;

  function automatic logic [7:0] ver_chr(input logic [1:0] k, input logic [3:0] idx);
    logic [63:0] w;
    case (k)
      2'd0:    w = "HTTP/0.9";
      2'd1:    w = "HTTP/1.0";
      2'd2:    w = "HTTP/1.1";
      default: w = '0;
    endcase
    return w[(6'd56 - {idx[2:0], 3'b000}) +: 8];
  endfunction

  function automatic logic [2:0] meth_narrow(input logic [2:0] mask, input logic [3:0] idx,
                                             input logic [7:0] c);
    logic [2:0] r;
    for (int k = 0; k < 3; k++) begin
      r[k] = mask[k] && (idx < meth_len(2'(k))) && (meth_chr(2'(k), idx) == c);
    end
    return r;
  endfunction

  function automatic logic [2:0] meth_finish(input logic [2:0] mask, input logic [3:0] idx);
    logic [2:0] r;
    for (int k = 0; k < 3; k++) begin
      r[k] = mask[k] && (meth_len(2'(k)) == idx);
    end
    return r;
  endfunction

  function automatic logic [2:0] ver_narrow(input logic [2:0] mask, input logic [3:0] idx,
                                            input logic [7:0] c);
    logic [2:0] r;
    for (int k = 0; k < 3; k++) begin
      r[k] = mask[k] && (idx < VerLen) && (ver_chr(2'(k), idx) == c);
    end
    return r;
  endfunction

  function automatic logic [2:0] ver_finish(input logic [2:0] mask, input logic [3:0] idx);
    return (idx == VerLen) ? mask : 3'b000;
  endfunction

  function automatic logic [1:0] code_of(input logic [2:0] mask);
    logic [1:0] r;
    if (mask[0]) begin
      r = 2'd0;
    end else if (mask[1]) begin
      r = 2'd1;
    end else if (mask[2]) begin
      r = 2'd2;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

>>> rtl/http_request_header_parser_core.sv
// Top level of the HTTP request header parser: input register, parser, result register.
// Depends on hrhp_pkg and hrhp_parse.
//
// Usage: request bytes enter on the s_axis channel, one per transfer; tuser set marks
// the first byte of a new request and clears all parse state. Results leave on m_axis:
// tuser 0 is a header tuple (name and value offsets), tuser 1 with tlast is the final
// verdict for the request. A tuple is void if the verdict that follows carries an error.
// After the verdict, bytes are taken and dropped until the next request start.
// Path: each byte goes through the input register, the parser and the result register.
// Throughput: one byte per cycle unless a result waits untaken; each byte is handled in
// a single pass of logic between the input register and the result register.
// Stall: a pending result waits in the result register; the input register still
// accepts a byte while the result is taken in the same cycle, otherwise it holds one
// byte and tready drops.
// Reset: rst_ni clears both stages and the parse state; the parser waits for offset 0.
module http_request_header_parser_core
  import hrhp_pkg::*;
#(
  parameter int unsigned BUF_BYTES    = 4096,
  parameter int unsigned HEADER_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STdataW-1:0] s_axis_tdata,  // byte_value
  input  logic               s_axis_tuser,  // new_request
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status[1:0], method[3:2], version[5:4], url_start[17:6], url_end[29:18],
  // name_start[41:30], name_end[53:42], value_start[65:54], value_end[77:66], zero pad
  output logic [MTdataW-1:0] m_axis_tdata,
  output logic               m_axis_tuser,  // kind
  output logic               m_axis_tlast   // last
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_new_q;
  logic               out_valid_q;
  logic [MTdataW-1:0] out_data_q;
  logic               out_user_q;
  logic               out_last_q;
  logic               out_free;
  logic               advance;
  logic               res_valid;
  result_t            res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  hrhp_parse #(
    .BUF_BYTES    (BUF_BYTES),
    .HEADER_SLOTS (HEADER_SLOTS)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .new_request_i (in_new_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_new_q  <= s_axis_tuser;
    end
    if (advance && res_valid) begin
      out_data_q <= {2'b00, res.value_end, res.value_start, res.name_end, res.name_start,
                     res.url_end, res.url_start, res.version, res.method, res.status};
      out_user_q <= res.kind;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/hrhp_parse.sv
// Parse state and per-byte next-state logic of the HTTP request header parser.
// Depends on hrhp_pkg; state advances on step_i, result is combinational.
module hrhp_parse
  import hrhp_pkg::*;
#(
  parameter int unsigned BUF_BYTES    = 4096,
  parameter int unsigned HEADER_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       new_request_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned PosW   = $clog2(BUF_BYTES);
  localparam int unsigned TcntW  = $clog2(HEADER_SLOTS / 2 + 1);
  localparam logic [PosW-1:0]  LastPos   = PosW'(BUF_BYTES - 2);
  localparam logic [TcntW-1:0] MaxTuples = TcntW'(HEADER_SLOTS / 2);

  localparam logic [1:0] TP_NONE    = 2'd0;
  localparam logic [1:0] TP_CR      = 2'd1;
  localparam logic [1:0] TP_CRLF    = 2'd2;
  localparam logic [1:0] TP_CRLFCR  = 2'd3;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_PATH,
    PH_VERSION,
    PH_HEADERS
  } phase_e;

  typedef struct packed {
    logic [PosW-1:0]  off;
    phase_e           phase;
    logic [2:0]       meth;
    logic [2:0]       ver;
    logic [3:0]       cidx;
    logic [PosW-1:0]  url_s;
    logic [PosW-1:0]  url_e;
    logic             name_act;
    logic             value_act;
    logic             skip;
    logic [PosW-1:0]  name_pos;
    logic [PosW-1:0]  colon_pos;
    logic [PosW-1:0]  value_pos;
    logic [TcntW-1:0] tcnt;
    logic [1:0]       term;
    status_e          verdict;
    logic             done;
  } st_t;

  function automatic st_t st_reset();
    st_t s;
    s         = '0;
    s.phase   = PH_METHOD;
    s.meth    = 3'b111;
    s.ver     = 3'b111;
    s.verdict = ST_OK;
    return s;
  endfunction

  st_t state_q, state_d;

  always_comb begin
    logic [PosW-1:0] pos;
    logic [PosW-1:0] at;
    logic [7:0]      ch;
    logic            en;
    logic            prev_cr;
    logic            term;
    logic            tuple;
    logic            is_letter;

    state_d     = new_request_i ? st_reset() : state_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    pos         = state_d.off;
    at          = '0;
    ch          = '0;
    en          = 1'b0;
    prev_cr     = (state_d.term == TP_CR) || (state_d.term == TP_CRLFCR);
    term        = 1'b0;
    tuple       = 1'b0;
    is_letter   = ((byte_i >= 8'h41) && (byte_i <= 8'h5a)) ||
                  ((byte_i >= 8'h61) && (byte_i <= 8'h7a));

    if (!state_d.done) begin
      if (byte_i == ChCr) begin
        state_d.term = (state_d.term == TP_CRLF) ? TP_CRLFCR : TP_CR;
      end else if (byte_i == ChLf) begin
        if (state_d.term == TP_CR) begin
          state_d.term = TP_CRLF;
        end else begin
          term         = (state_d.term == TP_CRLFCR);
          state_d.term = TP_NONE;
        end
      end else begin
        state_d.term = TP_NONE;
      end

      if (state_d.phase != PH_HEADERS) begin
        if (prev_cr && (byte_i == ChLf)) begin
          // request line complete
          at = pos - 1'b1;
          case (state_d.phase)
            PH_METHOD: begin
              state_d.meth    = meth_finish(state_d.meth, state_d.cidx);
              state_d.verdict = (|state_d.meth) ? ST_BAD_REQUEST : ST_NOT_ALLOWED;
            end
            PH_PATH: begin
              state_d.url_e   = at;
              state_d.verdict = (|state_d.meth) ? ST_BAD_REQUEST : ST_NOT_ALLOWED;
            end
            default: begin
              state_d.ver = ver_finish(state_d.ver, state_d.cidx);
              if (!(|state_d.meth)) begin
                state_d.verdict = ST_NOT_ALLOWED;
              end else if (state_d.url_e <= state_d.url_s) begin
                state_d.verdict = ST_BAD_REQUEST;
              end else if (!(|state_d.ver)) begin
                state_d.verdict = ST_BAD_REQUEST;
              end else begin
                state_d.verdict = ST_OK;
              end
            end
          endcase
          state_d.phase = PH_HEADERS;
        end else begin
          // a held-back CR turns out to be a plain byte, then the current byte
          for (int s = 0; s < 2; s++) begin
            if (s == 0) begin
              en = prev_cr;
              ch = ChCr;
              at = pos - 1'b1;
            end else begin
              en = (byte_i != ChCr);
              ch = byte_i;
              at = pos;
            end
            if (en) begin
              case (state_d.phase)
                PH_METHOD: begin
                  if (ch == ChSp) begin
                    state_d.meth  = meth_finish(state_d.meth, state_d.cidx);
                    state_d.url_s = at + 1'b1;
                    state_d.phase = PH_PATH;
                  end else begin
                    state_d.meth = meth_narrow(state_d.meth, state_d.cidx, ch);
                    if (state_d.cidx != 4'hf) state_d.cidx = state_d.cidx + 4'd1;
                  end
                end
                PH_PATH: begin
                  if (ch == ChSp) begin
                    state_d.url_e = at;
                    state_d.phase = PH_VERSION;
                    state_d.cidx  = '0;
                    state_d.ver   = 3'b111;
                  end
                end
                PH_VERSION: begin
                  state_d.ver = ver_narrow(state_d.ver, state_d.cidx, ch);
                  if (state_d.cidx != 4'hf) state_d.cidx = state_d.cidx + 4'd1;
                end
                default: ;
              endcase
            end
          end
        end
      end else if (!term && (state_d.verdict == ST_OK)) begin
        if (state_d.skip) begin
          if (byte_i == ChSp) begin
            state_d.value_pos = pos + 1'b1;
          end else begin
            state_d.skip = 1'b0;
          end
        end
        if (state_d.name_act && state_d.value_act &&
            ((byte_i == ChCr) || (byte_i == ChLf))) begin
          if (state_d.tcnt < MaxTuples) begin
            state_d.tcnt      = state_d.tcnt + 1'b1;
            tuple             = 1'b1;
            res_o.name_start  = OffW'(state_d.name_pos);
            res_o.name_end    = OffW'(state_d.colon_pos);
            res_o.value_start = OffW'(state_d.value_pos);
            res_o.value_end   = OffW'(pos);
            state_d.name_act  = 1'b0;
            state_d.value_act = 1'b0;
            state_d.skip      = 1'b0;
          end else begin
            state_d.verdict = ST_TOO_LARGE;
          end
        end else if (state_d.name_act && !state_d.value_act && (byte_i == ChColon)) begin
          state_d.colon_pos = pos;
          state_d.value_act = 1'b1;
          state_d.value_pos = pos + 1'b1;
          state_d.skip      = 1'b1;
        end else if (!state_d.name_act && is_letter) begin
          state_d.name_act = 1'b1;
          state_d.name_pos = pos;
        end
      end

      state_d.off = pos + 1'b1;

      if (term || (pos >= LastPos)) begin
        if (!term) state_d.verdict = ST_TOO_LARGE;
        state_d.done      = 1'b1;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_VERDICT;
        res_o.status      = state_d.verdict;
        res_o.last        = 1'b1;
        res_o.name_start  = '0;
        res_o.name_end    = '0;
        res_o.value_start = '0;
        res_o.value_end   = '0;
      end else if (tuple) begin
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_TUPLE;
        res_o.status = ST_OK;
        res_o.last   = 1'b0;
      end

      if (res_o.status == ST_OK) begin
        res_o.method    = method_e'(code_of(state_d.meth));
        res_o.version   = version_e'(code_of(state_d.ver));
        res_o.url_start = OffW'(state_d.url_s);
        res_o.url_end   = OffW'(state_d.url_e);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= st_reset();
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/hrhp_checker.sv
// Port-level assertions for http_request_header_parser_core, attached by bind.
// Depends on hrhp_pkg only for the port widths.
module hrhp_checker
  import hrhp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [STdataW-1:0] s_axis_tdata,
  input logic               s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [MTdataW-1:0] m_axis_tdata,
  input logic               m_axis_tuser,
  input logic               m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_tuple_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata[1:0] == 2'd0))
    else $error("tuple with last or error status");

  a_verdict_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[77:30] == '0))
    else $error("verdict without last or with header offsets");

endmodule

bind http_request_header_parser_core hrhp_checker u_hrhp_checker (.*);

>>> test/http_request_header_parser_core_tb.sv
// Self-checking testbench for http_request_header_parser_core: streams request bytes in,
// predicts header tuples and verdicts with a byte-level parser and checks every result.
// Depends on hrhp_pkg and the core RTL.
module http_request_header_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrhp_pkg::*;

  localparam int unsigned BufBytes    = 4096;
  localparam int unsigned HeaderSlots = 64;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomBytes = 1350;

  localparam string Letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string NameChars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_";
  localparam string PathChars  = "abcdefghijklmnopqrstuvwxyz0123456789/.%?=&";
  localparam string ValueChars = "abcdefghijklmnopqrstuvwxyzABCDEF0123456789 :;/.=,-\t";

  typedef enum int unsigned {
    LN_METHOD,
    LN_PATH,
    LN_VERSION,
    LN_HEADERS
  } line_phase_e;

  class request_scoreboard;
    line_phase_e phase;
    int unsigned offset, char_idx, url_s, url_e, name_pos, colon_pos, value_pos;
    int unsigned tuple_cnt;
    int unsigned crlf_prog;  // 0 none, 1 CR, 2 CR LF, 3 CR LF CR
    logic [2:0] meth_set, ver_set;
    bit name_on, value_on, skip_sp, finished;
    status_e verdict;
    result_t pending_results[$];
    int unsigned errors, tuples_seen, verdicts_seen, bad_verdicts;

    function new();
      clear();
    endfunction

    function void clear();
      offset    = 0;
      phase     = LN_METHOD;
      meth_set  = 3'b111;
      ver_set   = 3'b111;
      char_idx  = 0;
      url_s     = 0;
      url_e     = 0;
      name_on   = 0;
      value_on  = 0;
      skip_sp   = 0;
      name_pos  = 0;
      colon_pos = 0;
      value_pos = 0;
      tuple_cnt = 0;
      crlf_prog = 0;
      verdict   = ST_OK;
      finished  = 0;
    endfunction

    function string word_text(bit is_ver, int k);
      string w;
      if (is_ver) begin
        case (k)
          0:       w = "HTTP/0.9";
          1:       w = "HTTP/1.0";
          default: w = "HTTP/1.1";
        endcase
      end else begin
        case (k)
          0:       w = "GET";
          1:       w = "HEAD";
          default: w = "POST";
        endcase
      end
      return w;
    endfunction

    function logic [2:0] narrow_set(logic [2:0] set, bit is_ver, logic [7:0] c);
      logic [2:0] r;
      string w;
      for (int k = 0; k < 3; k++) begin
        w = word_text(is_ver, k);
        r[k] = set[k] && (char_idx < w.len()) && (w[char_idx] == c);
      end
      return r;
    endfunction

    function logic [2:0] close_set(logic [2:0] set, bit is_ver);
      logic [2:0] r;
      string w;
      for (int k = 0; k < 3; k++) begin
        w = word_text(is_ver, k);
        r[k] = set[k] && (w.len() == char_idx);
      end
      return r;
    endfunction

    function logic [1:0] first_code(logic [2:0] set);
      if (set[0]) return 2'd0;
      if (set[1]) return 2'd1;
      if (set[2]) return 2'd2;
      return 2'd0;
    endfunction

    function void bump();
      if (char_idx < 15) char_idx++;
    endfunction

    function void line_char(logic [7:0] c, int unsigned at);
      case (phase)
        LN_METHOD: begin
          if (c == ChSp) begin
            meth_set = close_set(meth_set, 0);
            url_s    = at + 1;
            phase    = LN_PATH;
          end else begin
            meth_set = narrow_set(meth_set, 0, c);
            bump();
          end
        end
        LN_PATH: begin
          if (c == ChSp) begin
            url_e    = at;
            phase    = LN_VERSION;
            char_idx = 0;
            ver_set  = 3'b111;
          end
        end
        default: begin
          ver_set = narrow_set(ver_set, 1, c);
          bump();
        end
      endcase
    endfunction

    function void end_line(int unsigned at);
      case (phase)
        LN_METHOD: begin
          meth_set = close_set(meth_set, 0);
          verdict  = (meth_set != 0) ? ST_BAD_REQUEST : ST_NOT_ALLOWED;
        end
        LN_PATH: begin
          url_e   = at;
          verdict = (meth_set != 0) ? ST_BAD_REQUEST : ST_NOT_ALLOWED;
        end
        default: begin
          ver_set = close_set(ver_set, 1);
          if (meth_set == 0) verdict = ST_NOT_ALLOWED;
          else if (url_e <= url_s) verdict = ST_BAD_REQUEST;
          else if (ver_set == 0) verdict = ST_BAD_REQUEST;
          else verdict = ST_OK;
        end
      endcase
      phase = LN_HEADERS;
    endfunction

    function result_t make_result(kind_e kind, status_e st,
                                  int unsigned ns, int unsigned ne,
                                  int unsigned vs, int unsigned ve);
      result_t r;
      r = '0;
      r.kind   = kind;
      r.status = st;
      if (st == ST_OK) begin
        r.method    = method_e'(first_code(meth_set));
        r.version   = version_e'(first_code(ver_set));
        r.url_start = url_s[11:0];
        r.url_end   = url_e[11:0];
      end
      r.name_start  = ns[11:0];
      r.name_end    = ne[11:0];
      r.value_start = vs[11:0];
      r.value_end   = ve[11:0];
      r.last        = (kind == KIND_VERDICT);
      return r;
    endfunction

    function bit header_byte(logic [7:0] c, int unsigned pos, output result_t r);
      if (skip_sp) begin
        if (c == ChSp) value_pos = pos + 1;
        else skip_sp = 0;
      end
      if (name_on && value_on && (c == ChCr || c == ChLf)) begin
        if (2 * tuple_cnt + 1 < HeaderSlots) begin
          tuple_cnt++;
          r = make_result(KIND_TUPLE, ST_OK, name_pos, colon_pos, value_pos, pos);
          name_on  = 0;
          value_on = 0;
          skip_sp  = 0;
          return 1;
        end
        verdict = ST_TOO_LARGE;
      end else if (name_on && !value_on && c == ChColon) begin
        colon_pos = pos;
        value_on  = 1;
        value_pos = pos + 1;
        skip_sp   = 1;
      end else if (!name_on && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
        name_on  = 1;
        name_pos = pos;
      end
      return 0;
    endfunction

    // called for every byte transfer on the input side
    function void parse_byte(logic [7:0] c, bit first);
      int unsigned pos, prev;
      bit prev_cr, term, tuple;
      result_t r;
      term  = 0;
      tuple = 0;
      if (first) clear();
      if (finished) return;
      pos     = offset;
      prev    = crlf_prog;
      prev_cr = (prev == 1 || prev == 3);
      if (c == ChCr) begin
        crlf_prog = (prev == 2) ? 3 : 1;
      end else if (c == ChLf) begin
        if (prev == 1) begin
          crlf_prog = 2;
        end else begin
          term      = (prev == 3);
          crlf_prog = 0;
        end
      end else begin
        crlf_prog = 0;
      end
      if (phase != LN_HEADERS) begin
        if (prev_cr && c == ChLf) begin
          end_line(pos - 1);
        end else begin
          if (prev_cr) line_char(ChCr, pos - 1);
          if (c != ChCr) line_char(c, pos);
        end
      end else if (!term && verdict == ST_OK) begin
        tuple = header_byte(c, pos, r);
      end
      offset = pos + 1;
      if (term || pos + 2 >= BufBytes) begin
        if (!term) verdict = ST_TOO_LARGE;
        finished = 1;
        pending_results.push_back(make_result(KIND_VERDICT, verdict, 0, 0, 0, 0));
      end else if (tuple) begin
        pending_results.push_back(r);
      end
    endfunction

    function void compare(string what, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
      end
    endfunction

    // called for every result transfer on the output side
    function void check_result(result_t got);
      result_t want;
      if (got.kind == KIND_VERDICT) begin
        verdicts_seen++;
        if (got.status != ST_OK) bad_verdicts++;
      end else begin
        tuples_seen++;
      end
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        end
        return;
      end
      want = pending_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("status", want.status, got.status);
      compare("method", want.method, got.method);
      compare("version", want.version, got.version);
      compare("url_start", want.url_start, got.url_start);
      compare("url_end", want.url_end, got.url_end);
      compare("name_start", want.name_start, got.name_start);
      compare("name_end", want.name_end, got.name_end);
      compare("value_start", want.value_start, got.value_start);
      compare("value_end", want.value_end, got.value_end);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  request_scoreboard sb = new();
  int unsigned send_idle = 27;
  int unsigned recv_idle = 52;
  int unsigned bytes_sent, requests_sent;
  int unsigned cycle_count = 0;
  bit hold_request = 1'b0;
  logic [7:0] req_bytes[$];

  http_request_header_parser_core #(
    .BUF_BYTES   (BufBytes),
    .HEADER_SLOTS(HeaderSlots)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending_results.size());
      $display("http_request_header_parser_core_tb: FAIL");
      $finish;
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void add_from(string set, int unsigned lo, int unsigned hi);
    repeat ($urandom_range(hi, lo)) req_bytes.push_back(set[$urandom_range(set.len() - 1)]);
  endfunction

  function automatic void add_noise(int unsigned lo, int unsigned hi);
    repeat ($urandom_range(hi, lo)) req_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // mostly well-formed requests with random content, some broken or truncated
  function automatic void build_random_request();
    int unsigned r, n;
    bit crlf_end;
    r = $urandom_range(99);
    if (r < 80) begin
      case ($urandom_range(2))
        0:       add_text("GET");
        1:       add_text("HEAD");
        default: add_text("POST");
      endcase
    end else if (r < 88) begin
      add_from(Letters, 0, 5);
    end else if (r < 94) begin
      add_noise(1, 4);
    end else if (r[0]) begin
      add_text("GE");
    end else begin
      add_text("HEADS");
    end
    if ($urandom_range(99) < 4) begin
      add_text("\015\n\015\n");
      return;
    end
    add_text(" ");
    if ($urandom_range(99) < 90) begin
      add_text("/");
      add_from(PathChars, 0, 8);
    end
    if ($urandom_range(99) < 5) add_noise(1, 2);
    if ($urandom_range(99) < 4) begin
      add_text("\015\n\015\n");
      return;
    end
    add_text(" ");
    r = $urandom_range(99);
    if (r < 85) begin
      case ($urandom_range(2))
        0:       add_text("HTTP/0.9");
        1:       add_text("HTTP/1.0");
        default: add_text("HTTP/1.1");
      endcase
    end else if (r < 92) begin
      case ($urandom_range(2))
        0:       add_text("HTTP/1.2");
        1:       add_text("HTTP/1");
        default: add_text("http/1.1");
      endcase
    end else begin
      add_from(PathChars, 0, 9);
    end
    add_text("\015\n");
    n = ($urandom_range(99) < 6) ? $urandom_range(36, 30) : $urandom_range(5);
    crlf_end = 1;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 80) begin
        add_from(Letters, 1, 1);
        add_from(NameChars, 0, 6);
        add_text(":");
        add_from(" ", 0, 3);
        add_from(ValueChars, 0, 10);
      end else if (r < 88) begin
        add_from(NameChars, 1, 6);
      end else if (r < 94) begin
        add_from(": 0123456789-", 1, 6);
      end else begin
        add_noise(1, 6);
      end
      r = $urandom_range(99);
      crlf_end = (r < 88);
      if (r < 88) add_text("\015\n");
      else if (r < 94) add_text("\n");
      else add_text("\015");
    end
    if ($urandom_range(99) < 92) begin
      if (crlf_end) add_text("\015\n");
      else add_text("\015\n\015\n");
    end
    if ($urandom_range(99) < 10) add_noise(1, 4);
  endfunction

  task automatic send_request(bit first);
    for (int i = 0; i < req_bytes.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= req_bytes[i];
      s_axis_tuser  <= first && (i == 0);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      sb.parse_byte(req_bytes[i], first && (i == 0));
      bytes_sent++;
    end
    requests_sent++;
    req_bytes.delete();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    result_t got;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind        = kind_e'(m_axis_tuser);
        got.status      = status_e'(m_axis_tdata[1:0]);
        got.method      = method_e'(m_axis_tdata[3:2]);
        got.version     = version_e'(m_axis_tdata[5:4]);
        got.url_start   = m_axis_tdata[17:6];
        got.url_end     = m_axis_tdata[29:18];
        got.name_start  = m_axis_tdata[41:30];
        got.name_end    = m_axis_tdata[53:42];
        got.value_start = m_axis_tdata[65:54];
        got.value_end   = m_axis_tdata[77:66];
        got.last        = m_axis_tlast;
        sb.check_result(got);
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text("GET / HTTP/1.1\015\nHost:  a\015\n\015\n");
    send_request(1);
    add_text("HEAD /x HTTP/1.0\015\nx:\015\n\015\n");
    send_request(1);
    // bytes after the verdict are dropped until the next request start
    add_text("POST /p HTTP/0.9\015\n\015\nzz");
    send_request(1);
    add_text("PUT / HTTP/1.1\015\n\015\n");
    send_request(1);
    add_text("GET  HTTP/1.1\015\n\015\n");
    send_request(1);
    add_text("GET / HTTP/2.0\015\n\015\n");
    send_request(1);
    add_text("GET\015\n\015\n");
    send_request(1);
    add_text("XY\015\n\015\n");
    send_request(1);
    add_text("GET /a\015\n\015\n");
    send_request(1);
    add_text("GE");
    req_bytes.push_back(8'h00);
    add_text("T / HTTP/1.1\015\n\015\n");
    send_request(1);
    // stray CR and LF in the path, name lines without colon, NUL in a value
    add_text("GET /a\015b\nc HTTP/1.1\015\n1x\015\nk\015\nv:");
    req_bytes.push_back(8'h00);
    add_text("w\nQ: \015\015\n\015\n");
    send_request(1);
    add_text("GET /t HTTP/1.1\015\n");
    repeat (HeaderSlots / 2 + 1) add_text("a:b\015\n");
    add_text("\015\n");
    send_request(1);
    // buffer fills with a CR that would otherwise close a header value
    add_text("GET /big HTTP/1.1\015\n");
    while (req_bytes.size() < BufBytes - 300) begin
      add_text("Xa: ");
      add_from(ValueChars, 200, 200);
      add_text("\015\n");
    end
    add_text("Yb: ");
    while (req_bytes.size() < BufBytes - 2) add_text("v");
    add_text("\015\nzz");
    send_request(1);
    add_text("FOO / HTTP/1.1\015\n");
    add_from(Letters, BufBytes, BufBytes);
    send_request(1);

    for (int p = 0; p < 3; p++) begin
      send_idle    = (p == 0) ? 27 : (p == 1) ? 52 : 0;
      recv_idle    = (p == 0) ? 52 : (p == 1) ? 27 : 0;
      hold_request = (p == 2);
      target       = bytes_sent + RandomBytes / 3;
      while (bytes_sent < target) begin
        build_random_request();
        send_request($urandom_range(99) >= 3);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d request bytes in %0d requests; %0d header tuples and %0d verdicts checked",
             bytes_sent, requests_sent, sb.tuples_seen, sb.verdicts_seen);
    $display("%0d verdicts carried an error status, %0d mismatches", sb.bad_verdicts,
             sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("http_request_header_parser_core_tb: PASS");
    end else begin
      $display("http_request_header_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule
